// ----- rtl/psq_pkg.sv -----
// Package with shared types and constants of the power sample qualifier.
`timescale 1ns / 1ps
package psq_pkg;
  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] EXP_MASK = 32'h7F80_0000;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] GAP_LIMIT_RESET = 32'd1000;
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_GAP_LIMIT = 2'd0;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_NONFINITE = 2'd2;
  localparam logic [1:0] ST_LATE = 2'd3;

  typedef struct packed {
    logic [63:0] time_us;
    logic        voltage_read_ok;
    logic        current_read_ok;
    logic        reference_read_ok;
    logic [31:0] voltage_bits;
    logic [31:0] current_bits;
    logic [31:0] reference_bits;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] sample_time_us;
    logic [31:0] sample_voltage;
    logic [31:0] sample_current;
    logic [31:0] sample_reference;
    logic [31:0] accepted_total;
    logic [31:0] failure_total;
    logic [31:0] late_total;
    logic [31:0] bad_value_total;
    logic [31:0] gap_total;
    logic [63:0] longest_interval_us;
    logic        trouble;
  } out_item_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + 32'd1;
  endfunction

  function automatic logic non_finite(input logic [31:0] b);
    non_finite = ((b & EXP_MASK) == EXP_MASK);
  endfunction
endpackage

// ----- rtl/psq_if.sv -----
// Valid/ready channel interfaces for input and result items.
`timescale 1ns / 1ps
interface psq_in_if import psq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psq_out_if import psq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/power_sample_qualifier.sv -----
// Top level of the power sample qualifier: registers, checks and counters.
`timescale 1ns / 1ps
// An accepted item is held in the input register, and its result item is then
// offered from the result register.
// Throughput: one item per cycle; the checks run between the input register and
// the result register, and each stage moves on whenever the stage after it is
// empty or being emptied in the same cycle.
// Reset (synchronous, rst_n low) clears all counters, the previous timestamp and
// both valid flags, and sets the gap limit to 1000 microseconds.
module power_sample_qualifier import psq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  psq_in_if.sink                in_ch,
  psq_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  logic [31:0] gap_limit_r;
  logic [63:0] prev_time_r, longest_r;
  logic        have_prev_r;
  logic [31:0] acc_r, fail_r, late_r, bad_r, gap_r;
  logic        out_valid_r;
  out_item_t   out_r, res;
  in_item_t    in_r;
  logic        in_valid_r;

  logic take;
  logic adv;
  logic load;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_GAP_LIMIT) ? gap_limit_r : 32'd0;

  // The result register is a single stage; the input register hands its item
  // on when the result register drains, and new input lands when it moves on.
  assign adv = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || adv;
  assign load = in_ch.valid && in_ch.ready;
  assign take = in_valid_r && adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  logic [63:0] interval;
  logic        req_fail, nonfin, late;
  assign interval = in_r.time_us - prev_time_r;
  assign req_fail = !in_r.voltage_read_ok || !in_r.current_read_ok;
  assign nonfin = non_finite(in_r.voltage_bits) ||
                  non_finite(in_r.current_bits);
  assign late = have_prev_r && (in_r.time_us <= prev_time_r);

  logic [31:0] acc_n, fail_n, late_n, bad_n, gap_n;
  logic [63:0] longest_n;

  always_comb begin
    acc_n = acc_r; fail_n = fail_r; late_n = late_r; bad_n = bad_r;
    gap_n = gap_r; longest_n = longest_r;
    res = '0;
    if (req_fail) begin
      fail_n = sat_inc(fail_r);
      res.status = ST_FAIL;
    end else if (nonfin) begin
      bad_n = sat_inc(bad_r);
      res.status = ST_NONFINITE;
    end else if (late) begin
      late_n = sat_inc(late_r);
      res.status = ST_LATE;
    end else begin
      // Interval bookkeeping only once a previous sample exists.
      if (have_prev_r) begin
        if (interval > {32'd0, gap_limit_r}) gap_n = sat_inc(gap_r);
        if (interval > longest_r) longest_n = interval;
      end
      acc_n = sat_inc(acc_r);
      res.status = ST_OK;
      res.sample_time_us = in_r.time_us;
      res.sample_voltage = in_r.voltage_bits;
      res.sample_current = in_r.current_bits;
      res.sample_reference = in_r.reference_read_ok ?
                             in_r.reference_bits : QNAN_BITS;
    end
    res.accepted_total = acc_n;
    res.failure_total = fail_n;
    res.late_total = late_n;
    res.bad_value_total = bad_n;
    res.gap_total = gap_n;
    res.longest_interval_us = longest_n;
    res.trouble = (fail_n != 0) || (late_n != 0) || (bad_n != 0) || (gap_n != 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= GAP_LIMIT_RESET;
      prev_time_r <= '0; have_prev_r <= 1'b0; longest_r <= '0;
      acc_r <= '0; fail_r <= '0; late_r <= '0; bad_r <= '0; gap_r <= '0;
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_GAP_LIMIT)
        gap_limit_r <= cfg_pwdata;
      if (load) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (take) begin
        acc_r <= acc_n; fail_r <= fail_n; late_r <= late_n; bad_r <= bad_n;
        gap_r <= gap_n; longest_r <= longest_n;
        if (res.status == ST_OK) begin
          prev_time_r <= in_r.time_us;
          have_prev_r <= 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) in_r <= in_ch.data;
    if (take) out_r <= res;
  end

  a_total_grows: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (acc_r + fail_r + late_r + bad_r >= $past(acc_r + fail_r + late_r + bad_r)))
    else $error("counter total fell");
  a_ok_sets_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res.status == ST_OK) |=> have_prev_r)
    else $error("accepted sample did not set previous");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_r)))
    else $error("result lost under stall");
endmodule

// ----- test/tb_power_sample_qualifier.sv -----
// Testbench for the power sample qualifier: predicted results checked against the block.
`timescale 1ns / 1ps

// Holds a copy of the qualifier state and a queue of predicted result items.
class qualifier_scoreboard;
  psq_pkg::out_item_t predicted_q[$];
  logic [31:0] gap_limit;
  logic [63:0] last_time;
  logic        have_last;
  logic [31:0] accepted_cnt;
  logic [31:0] failure_cnt;
  logic [31:0] late_cnt;
  logic [31:0] bad_cnt;
  logic [31:0] gap_cnt;
  logic [63:0] longest;
  int          mismatches;

  function new();
    gap_limit = psq_pkg::GAP_LIMIT_RESET;
    last_time = '0;
    have_last = 1'b0;
    accepted_cnt = '0;
    failure_cnt = '0;
    late_cnt = '0;
    bad_cnt = '0;
    gap_cnt = '0;
    longest = '0;
    mismatches = 0;
  endfunction

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic logic exp_all_ones(input logic [31:0] b);
    return b[30:23] == 8'hFF;
  endfunction

  // Works out the result of one accepted sample and queues it.
  function void note_sample(input psq_pkg::in_item_t it);
    psq_pkg::out_item_t r;
    logic [63:0] interval;
    r = '0;
    if (!it.voltage_read_ok || !it.current_read_ok) begin
      failure_cnt = bump(failure_cnt);
      r.status = psq_pkg::ST_FAIL;
    end else if (exp_all_ones(it.voltage_bits) || exp_all_ones(it.current_bits)) begin
      bad_cnt = bump(bad_cnt);
      r.status = psq_pkg::ST_NONFINITE;
    end else if (have_last && it.time_us <= last_time) begin
      late_cnt = bump(late_cnt);
      r.status = psq_pkg::ST_LATE;
    end else begin
      if (have_last) begin
        interval = it.time_us - last_time;
        if (interval > {32'd0, gap_limit}) gap_cnt = bump(gap_cnt);
        if (interval > longest) longest = interval;
      end
      last_time = it.time_us;
      have_last = 1'b1;
      accepted_cnt = bump(accepted_cnt);
      r.status = psq_pkg::ST_OK;
      r.sample_time_us = it.time_us;
      r.sample_voltage = it.voltage_bits;
      r.sample_current = it.current_bits;
      r.sample_reference = it.reference_read_ok ? it.reference_bits : 32'h7FC0_0000;
    end
    r.accepted_total = accepted_cnt;
    r.failure_total = failure_cnt;
    r.late_total = late_cnt;
    r.bad_value_total = bad_cnt;
    r.gap_total = gap_cnt;
    r.longest_interval_us = longest;
    r.trouble = (failure_cnt != 0) || (late_cnt != 0) || (bad_cnt != 0) || (gap_cnt != 0);
    predicted_q.push_back(r);
  endfunction

  function void check_result(input psq_pkg::out_item_t got);
    psq_pkg::out_item_t want;
    if (predicted_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item: %h", got);
      return;
    end
    want = predicted_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result mismatch at %0t", $time);
        $display("  expected st=%0d t=%h v=%h c=%h r=%h", want.status, want.sample_time_us,
                 want.sample_voltage, want.sample_current, want.sample_reference);
        $display("  actual   st=%0d t=%h v=%h c=%h r=%h", got.status, got.sample_time_us,
                 got.sample_voltage, got.sample_current, got.sample_reference);
        $display("  expected acc=%h fail=%h late=%h bad=%h gap=%h long=%h tr=%b",
                 want.accepted_total, want.failure_total, want.late_total,
                 want.bad_value_total, want.gap_total, want.longest_interval_us, want.trouble);
        $display("  actual   acc=%h fail=%h late=%h bad=%h gap=%h long=%h tr=%b",
                 got.accepted_total, got.failure_total, got.late_total,
                 got.bad_value_total, got.gap_total, got.longest_interval_us, got.trouble);
      end
    end
  endfunction
endclass

module tb_power_sample_qualifier;
  import psq_pkg::*;

  // Watchdog limit in cycles with no handshake on either channel. The longest
  // honest pause is the settle wait before a register write, far below this.
  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  psq_in_if  in_ch ();
  psq_out_if out_ch ();

  power_sample_qualifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch.sink),
    .out_ch     (out_ch.source),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  qualifier_scoreboard sb;

  // Idling control: both sides idle about 12 percent of the time unless the
  // quiet flag is set, which gives a long stretch at full rate.
  logic quiet;
  int   stall_cycles;
  // Timestamp of the last sample that the stimulus meant to be in order.
  logic [63:0] clock_us;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // The result side: ready is chosen at each falling edge, and an item is
  // taken at the rising edge when valid and ready are both high.
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // The watchdog counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_power_sample_qualifier: errors");
        $finish;
      end
    end
  end

  // Offers one item and holds it until it is accepted. The prediction is made
  // at the accepting edge, so the scoreboard sees items in order. Valid stays
  // high after acceptance, so the next item can follow with no gap.
  task automatic send_sample(input in_item_t it);
    if (!quiet) begin
      while ($urandom_range(99) < 12) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(it);
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (sb.predicted_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes the gap limit with a setup and an access cycle, only when idle.
  task automatic write_gap_limit(input logic [31:0] value);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_GAP_LIMIT;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.gap_limit = value;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // A finite reading: exponent kept below all ones, all else random.
  function automatic logic [31:0] finite_bits();
    logic [31:0] b;
    b = $urandom;
    if (b[30:23] == 8'hFF) b[23] = 1'b0;
    return b;
  endfunction

  function automatic logic [31:0] odd_bits();
    logic [31:0] b;
    b = $urandom;
    b[30:23] = 8'hFF;
    return b;
  endfunction

  // Builds a random sample. Mostly well formed with a timestamp moving
  // forward by a short or a long step; the rest are failed reads, non-finite
  // readings, timestamps that go back or repeat, or fully random timestamps.
  function automatic in_item_t random_sample();
    in_item_t it;
    int pick;
    logic [63:0] step;
    pick = $urandom_range(99);
    it.voltage_read_ok = 1'b1;
    it.current_read_ok = 1'b1;
    it.reference_read_ok = ($urandom_range(9) != 0);
    it.voltage_bits = finite_bits();
    it.current_bits = finite_bits();
    it.reference_bits = $urandom;
    case ($urandom_range(3))
      0: step = 64'($urandom_range(sb.gap_limit > 4 ? 4 : 1, 1));
      1: step = {32'd0, sb.gap_limit} + 64'($urandom_range(2)) - 64'd1;
      2: step = 64'($urandom_range(3000, 1));
      default: step = {$urandom_range(3), $urandom};
    endcase
    if (step == 0) step = 1;
    it.time_us = clock_us + step;
    if (pick < 8) begin
      {it.voltage_read_ok, it.current_read_ok} = 2'($urandom_range(2));
    end else if (pick < 15) begin
      if ($urandom_range(1)) it.voltage_bits = odd_bits();
      else it.current_bits = odd_bits();
      if ($urandom_range(3) == 0) it.current_bits = odd_bits();
    end else if (pick < 22) begin
      it.time_us = clock_us - 64'($urandom_range(3));
    end else if (pick < 24) begin
      it.time_us = {$urandom, $urandom};
    end
    return it;
  endfunction

  task automatic send_and_track(input in_item_t it);
    logic ok;
    ok = it.voltage_read_ok && it.current_read_ok && it.voltage_bits[30:23] != 8'hFF &&
         it.current_bits[30:23] != 8'hFF && (!sb.have_last || it.time_us > sb.last_time);
    send_sample(it);
    if (ok) clock_us = it.time_us;
  endtask

  task automatic random_phase(input int count);
    for (int k = 0; k < count; k++) begin
      send_and_track(random_sample());
    end
  endtask

  function automatic in_item_t plain(input logic [63:0] t);
    in_item_t it;
    it = '0;
    it.time_us = t;
    it.voltage_read_ok = 1'b1;
    it.current_read_ok = 1'b1;
    it.reference_read_ok = 1'b1;
    it.voltage_bits = 32'h4140_0000;
    it.current_bits = 32'h3F80_0000;
    it.reference_bits = 32'h3F00_0000;
    return it;
  endfunction

  initial begin
    in_item_t it;
    sb = new();
    quiet = 1'b0;
    clock_us = '0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    stall_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. The first accepted sample carries time zero, so it
    // has no interval and cannot be late.
    it = plain(64'd0);
    it.reference_read_ok = 1'b0;
    send_and_track(it);
    // Same time again is late.
    send_and_track(plain(64'd0));
    // Failed reads in each combination, one with a bad value that must not count.
    it = plain(64'd5);
    it.voltage_read_ok = 1'b0;
    it.voltage_bits = 32'h7F80_0000;
    send_and_track(it);
    it = plain(64'd5);
    it.current_read_ok = 1'b0;
    send_and_track(it);
    it = plain(64'd5);
    it.voltage_read_ok = 1'b0;
    it.current_read_ok = 1'b0;
    send_and_track(it);
    // Non-finite voltage, then current: infinity and NaN patterns, both signs.
    it = plain(64'd0);
    it.voltage_bits = 32'hFF80_0000;
    send_and_track(it);
    it = plain(64'd6);
    it.current_bits = 32'h7FFF_FFFF;
    send_and_track(it);
    // A non-finite reference is passed through untouched.
    it = plain(64'd1000);
    it.reference_bits = 32'hFFFF_FFFF;
    it.voltage_bits = 32'hFF7F_FFFF;
    it.current_bits = 32'h0000_0000;
    send_and_track(it);
    // Interval exactly at the limit is not a gap; one above is.
    send_and_track(plain(64'd2000));
    send_and_track(plain(64'd3001));
    send_and_track(plain(64'd3000));

    // Random part, run while accepted samples are still possible.
    random_phase(200);
    write_gap_limit(32'd1);
    quiet = 1'b1;
    random_phase(120);
    quiet = 1'b0;
    // The sender pauses until every result has come.
    drain();
    write_gap_limit($urandom);
    random_phase(220);

    // Largest timestamp, then largest interval check against a zero limit.
    // After the top timestamp every later sample with good reads and finite values is late.
    write_gap_limit(32'd0);
    send_and_track(plain(clock_us + 64'd1));
    send_and_track(plain(64'hFFFF_FFFF_FFFF_FFFF));
    send_and_track(plain(64'hFFFF_FFFF_FFFF_FFFF));
    for (int k = 0; k < 6; k++) send_and_track(random_sample());
    drain();
    repeat (10) @(negedge clk);
    if (sb.mismatches == 0 && sb.predicted_q.size() == 0) begin
      $display("tb_power_sample_qualifier: clean");
    end else begin
      $display("tb_power_sample_qualifier: errors");
    end
    $finish;
  end
endmodule
